@@ design/rte_pkg.sv @@
// Shared types, constants and calendar tables for the datetime-to-epoch converter.
// No dependencies; imported by rtc_datetime_to_epoch and rte_checker.
package rte_pkg;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_MIN_YEAR      = 2'd0,
        REG_MAX_YEAR      = 2'd1,
        REG_INVALID_STAMP = 2'd2
    } reg_idx_t;

    localparam logic [15:0] MIN_YEAR_RST      = 16'd2024;
    localparam logic [15:0] MAX_YEAR_RST      = 16'd2099;
    localparam logic [31:0] INVALID_STAMP_RST = 32'd0;

    // Era arithmetic. Year is biased by one era (+400) so every value stays
    // non-negative; the bias is folded back into DAY_OFFSET.
    localparam logic [16:0] YEAR_BIAS    = 17'd400;
    localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
    localparam logic [26:0] DAY_OFFSET   = 27'd865565;   // 719468 + 146097
    // floor(x / 25) for x < 2^13 as (x * RECIP_25) >> 17
    localparam logic [12:0] RECIP_25     = 13'd5243;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;

    // Cycles from an accepted start to its done strobe
    localparam int unsigned LATENCY = 6;

    // Lowest day number a plausible word can carry (0000-01-01)
    localparam logic signed [25:0] MIN_DAY_NUMBER = -26'sd719528;

    // Days in month for a common year; zero for a bad month code
    function automatic logic [4:0] month_len(input logic [7:0] month);
        logic [4:0] len;
        case (month)
            8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: len = 5'd31;
            8'd4, 8'd6, 8'd9, 8'd11:                     len = 5'd30;
            8'd2:                                        len = 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    // Day of the March-based year on which a month starts, (153*mp+2)/5
    function automatic logic [8:0] month_start(input logic [7:0] month);
        logic [8:0] start_day;
        case (month)
            8'd3:    start_day = 9'd0;
            8'd4:    start_day = 9'd31;
            8'd5:    start_day = 9'd61;
            8'd6:    start_day = 9'd92;
            8'd7:    start_day = 9'd122;
            8'd8:    start_day = 9'd153;
            8'd9:    start_day = 9'd184;
            8'd10:   start_day = 9'd214;
            8'd11:   start_day = 9'd245;
            8'd12:   start_day = 9'd275;
            8'd1:    start_day = 9'd306;
            8'd2:    start_day = 9'd337;
            default: start_day = 9'd0;
        endcase
        return start_day;
    endfunction

endpackage

@@ design/rtc_datetime_to_epoch.sv @@
// Calendar reading to Unix time converter: six-stage pipeline plus APB config registers.
// Depends on rte_pkg (register indexes, calendar tables, era constants).
//
// One calendar reading is taken on every cycle that start is high; busy is always
// low. Each word leaves the register stages on plausible/day_number/epoch_seconds
// in order, marked by a one-cycle done strobe; the receiver cannot stall,
// so nothing is buffered. The six register stages are: input capture, year
// division by 400 and range checks, year-of-era and day-of-year, day-of-era and
// era days, day number, and the output word after the 86400-second multiply. A
// reading that fails the checks gives plausible = 0, day_number = 0 and
// epoch_seconds = invalid_stamp. The registers min_year, max_year, invalid_stamp
// (0x0, 0x4, 0x8) must be written only with no word in flight; unchecked by the block.
module rtc_datetime_to_epoch
    import rte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // APB config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // command channel
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        cal_year,
    input  logic [7:0]         cal_month,
    input  logic [7:0]         cal_day,
    input  logic [7:0]         cal_hour,
    input  logic [7:0]         cal_minute,
    input  logic [7:0]         cal_second,
    // result channel
    output logic               done,
    output logic               plausible,
    output logic signed [25:0] day_number,
    output logic [31:0]        epoch_seconds
);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [15:0] min_year_reg;
    logic [15:0] max_year_reg;
    logic [31:0] invalid_stamp_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg      <= MIN_YEAR_RST;
            max_year_reg      <= MAX_YEAR_RST;
            invalid_stamp_reg <= INVALID_STAMP_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MIN_YEAR:      min_year_reg      <= pwdata[15:0];
                REG_MAX_YEAR:      max_year_reg      <= pwdata[15:0];
                REG_INVALID_STAMP: invalid_stamp_reg <= pwdata;
                default:           ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_idx)
            REG_MIN_YEAR:      prdata = {16'd0, min_year_reg};
            REG_MAX_YEAR:      prdata = {16'd0, max_year_reg};
            REG_INVALID_STAMP: prdata = invalid_stamp_reg;
            default:           prdata = 32'd0;
        endcase
    end

    // full rate, never stalls
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage A: capture the reading
    // ------------------------------------------------------------------
    logic        a_vld_reg;
    logic [15:0] a_year_reg;
    logic [7:0]  a_month_reg, a_day_reg, a_hour_reg, a_min_reg, a_sec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else
            a_vld_reg <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        a_year_reg  <= cal_year;
        a_month_reg <= cal_month;
        a_day_reg   <= cal_day;
        a_hour_reg  <= cal_hour;
        a_min_reg   <= cal_minute;
        a_sec_reg   <= cal_second;
    end

    // biased March-based year and its era, era = ypl / 400 = (ypl >> 4) / 25
    logic        a_jan_feb;
    logic [16:0] a_ypl;
    logic [25:0] a_q_prod;
    logic [7:0]  b_q_next;
    logic        b_ok_next;
    logic        b_feb29_next;
    logic [16:0] b_tod_next;
    logic [4:0]  a_mlen;

    assign a_jan_feb = (a_month_reg <= 8'd2);
    assign a_ypl     = {1'b0, a_year_reg} + YEAR_BIAS - {16'd0, a_jan_feb};
    assign a_q_prod  = 26'(a_ypl[16:4]) * 26'(RECIP_25);
    assign b_q_next  = a_q_prod[24:17];

    // range checks; the 29th of February waits for the leap test
    assign a_mlen       = month_len(a_month_reg);
    assign b_feb29_next = (a_month_reg == 8'd2) && (a_day_reg == 8'd29);
    assign b_ok_next    = (a_year_reg >= min_year_reg) && (a_year_reg <= max_year_reg)
                        && (a_day_reg != 8'd0)
                        && ((a_day_reg <= {3'd0, a_mlen}) || b_feb29_next)
                        && (a_hour_reg <= 8'd23) && (a_min_reg <= 8'd59)
                        && (a_sec_reg <= 8'd59);
    // wraps only for garbage inputs, which are masked later
    assign b_tod_next   = 17'(17'(a_hour_reg) * 17'd3600 + 17'(a_min_reg) * 17'd60
                        + 17'(a_sec_reg));

    // ------------------------------------------------------------------
    // Stage B: year of era and day of year
    // ------------------------------------------------------------------
    logic        b_vld_reg;
    logic [16:0] b_ypl_reg;
    logic [7:0]  b_q_reg;
    logic [7:0]  b_month_reg, b_day_reg;
    logic        b_ok_reg, b_feb29_reg;
    logic [16:0] b_tod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        b_ypl_reg   <= a_ypl;
        b_q_reg     <= b_q_next;
        b_month_reg <= a_month_reg;
        b_day_reg   <= a_day_reg;
        b_ok_reg    <= b_ok_next;
        b_feb29_reg <= b_feb29_next;
        b_tod_reg   <= b_tod_next;
    end

    logic [16:0] b_yoe_full;
    logic [8:0]  c_yoe_next;
    logic [8:0]  c_doy_next;

    assign b_yoe_full = b_ypl_reg - 17'(17'(b_q_reg) * 17'd400);
    assign c_yoe_next = b_yoe_full[8:0];
    assign c_doy_next = 9'(month_start(b_month_reg) + 9'(b_day_reg) - 9'd1);

    // ------------------------------------------------------------------
    // Stage C: day of era, era days and leap check
    // ------------------------------------------------------------------
    logic        c_vld_reg;
    logic [8:0]  c_yoe_reg, c_doy_reg;
    logic [7:0]  c_q_reg;
    logic        c_ok_reg, c_feb29_reg;
    logic [16:0] c_tod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else
            c_vld_reg <= b_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        c_yoe_reg   <= c_yoe_next;
        c_doy_reg   <= c_doy_next;
        c_q_reg     <= b_q_reg;
        c_ok_reg    <= b_ok_reg;
        c_feb29_reg <= b_feb29_reg;
        c_tod_reg   <= b_tod_reg;
    end

    // For February the calendar year equals yoe + 1 modulo 400
    logic [9:0]  c_cal_mod;
    logic        c_leap;
    logic [1:0]  c_cent;
    logic [17:0] d_doe_next;
    logic [24:0] d_era_next;
    logic        d_ok_next;

    assign c_cal_mod = {1'b0, c_yoe_reg} + 10'd1;
    assign c_leap    = (c_cal_mod[1:0] == 2'b00)
                     && !((c_cal_mod == 10'd100) || (c_cal_mod == 10'd200)
                          || (c_cal_mod == 10'd300));

    // yoe / 100 over 0..399
    always_comb
    begin
        if (c_yoe_reg >= 9'd300)
            c_cent = 2'd3;
        else if (c_yoe_reg >= 9'd200)
            c_cent = 2'd2;
        else if (c_yoe_reg >= 9'd100)
            c_cent = 2'd1;
        else
            c_cent = 2'd0;
    end

    assign d_doe_next = 18'(18'(c_yoe_reg) * 18'd365) + 18'(c_yoe_reg[8:2])
                      - 18'(c_cent) + 18'(c_doy_reg);
    assign d_era_next = 25'(25'(c_q_reg) * 25'(DAYS_PER_ERA));
    assign d_ok_next  = c_ok_reg && (!c_feb29_reg || c_leap);

    // ------------------------------------------------------------------
    // Stage D: day number
    // ------------------------------------------------------------------
    logic        d_vld_reg;
    logic [17:0] d_doe_reg;
    logic [24:0] d_era_reg;
    logic        d_ok_reg;
    logic [16:0] d_tod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= 1'b0;
        else
            d_vld_reg <= c_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        d_doe_reg <= d_doe_next;
        d_era_reg <= d_era_next;
        d_ok_reg  <= d_ok_next;
        d_tod_reg <= c_tod_reg;
    end

    logic [26:0] d_days_full;
    assign d_days_full = 27'(d_era_reg) + 27'(d_doe_reg) - DAY_OFFSET;

    // ------------------------------------------------------------------
    // Stage E: seconds = days * 86400 + time of day, modulo 2^32
    // ------------------------------------------------------------------
    logic               e_vld_reg;
    logic signed [25:0] e_days_reg;
    logic               e_ok_reg;
    logic [16:0]        e_tod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else
            e_vld_reg <= d_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        e_days_reg <= d_days_full[25:0];
        e_ok_reg   <= d_ok_reg;
        e_tod_reg  <= d_tod_reg;
    end

    logic [31:0] e_days_ext;
    logic [31:0] epoch_next;
    logic [25:0] day_number_next;

    assign e_days_ext      = {{6{e_days_reg[25]}}, e_days_reg};
    assign epoch_next      = e_ok_reg
                           ? 32'(e_days_ext * 32'(SECS_PER_DAY) + 32'(e_tod_reg))
                           : invalid_stamp_reg;
    assign day_number_next = e_ok_reg ? e_days_reg : 26'd0;

    // output word register
    logic               done_reg;
    logic               plausible_reg;
    logic signed [25:0] day_number_reg;
    logic [31:0]        epoch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= e_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        plausible_reg  <= e_ok_reg;
        day_number_reg <= day_number_next;
        epoch_reg      <= epoch_next;
    end

    assign done          = done_reg;
    assign plausible     = plausible_reg;
    assign day_number    = day_number_reg;
    assign epoch_seconds = epoch_reg;

endmodule

@@ design/rte_checker.sv @@
// Port-level assertions for rtc_datetime_to_epoch, attached by bind.
// Depends on rte_pkg (LATENCY, MIN_DAY_NUMBER) and the top-level port names.
module rte_checker
    import rte_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic               plausible,
    input logic signed [25:0] day_number
);

    // every accepted reading yields a word after the fixed latency
    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(LATENCY) done)
        else $error("accepted reading produced no done strobe");

    // no word appears without a reading accepted before it
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("done strobe without a matching accepted reading");

    // an implausible reading reports day zero
    a_bad_day_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !plausible) |-> (day_number == 26'sd0))
        else $error("implausible word carries a nonzero day number");

    // a plausible day number never falls before year zero
    a_day_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && plausible) |-> (day_number >= MIN_DAY_NUMBER))
        else $error("plausible day number below the calendar floor");

endmodule

bind rtc_datetime_to_epoch rte_checker u_rte_checker (.*);
